### sv/mmc_pkg.sv
// ---------------------------------------------------------------------------
// mmc_pkg
// Shared constants, types and prefix tables of the mailbox message counter.
// ---------------------------------------------------------------------------
`default_nettype none

package mmc_pkg;

  localparam int LINE_CHUNK_DEF = 1024;

  localparam int FROM_LEN   = 5;
  localparam int STATUS_LEN = 8;
  localparam int IMAP_LEN   = 8;

  localparam logic [7:0] CHAR_NL = 8'h0A;
  localparam logic [7:0] CHAR_R  = 8'h52;

  // Summary of a chunk that ends on the current beat.
  typedef struct packed {
    logic close;
    logic blank;
    logic is_from;
    logic is_status;
    logic is_imap;
    logic r_seen;
  } chunk_close_t;

  // "From "
  function automatic logic [7:0] from_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h46;
      3'd1:    c = 8'h72;
      3'd2:    c = 8'h6F;
      3'd3:    c = 8'h6D;
      default: c = 8'h20;
    endcase
    return c;
  endfunction

  // "Status: "
  function automatic logic [7:0] status_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h53;
      3'd1:    c = 8'h74;
      3'd2:    c = 8'h61;
      3'd3:    c = 8'h74;
      3'd4:    c = 8'h75;
      3'd5:    c = 8'h73;
      3'd6:    c = 8'h3A;
      default: c = 8'h20;
    endcase
    return c;
  endfunction

  // "X-IMAP: "
  function automatic logic [7:0] imap_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h58;
      3'd1:    c = 8'h2D;
      3'd2:    c = 8'h49;
      3'd3:    c = 8'h4D;
      3'd4:    c = 8'h41;
      3'd5:    c = 8'h50;
      3'd6:    c = 8'h3A;
      default: c = 8'h20;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### sv/mmc_chunk.sv
// ---------------------------------------------------------------------------
// mmc_chunk
// Cuts the byte stream into chunks and classifies each chunk as it closes.
// ---------------------------------------------------------------------------
`default_nettype none

module mmc_chunk
  import mmc_pkg::*;
#(
  parameter int LINE_CHUNK = LINE_CHUNK_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         en,
  input  wire logic [7:0]   data_byte,
  input  wire logic         byte_present,
  input  wire logic         end_of_file,
  output chunk_close_t      chunk
);

  localparam int POS_W = $clog2(LINE_CHUNK);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(LINE_CHUNK - 2);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             from_r, from_nxt;
  logic             status_r, status_nxt;
  logic             imap_r, imap_nxt;
  logic             rseen_r, rseen_nxt;
  logic             close;

  always_comb begin
    from_nxt   = from_r;
    status_nxt = status_r;
    imap_nxt   = imap_r;
    rseen_nxt  = rseen_r;
    pos_nxt    = pos_r + POS_W'(byte_present);
    if (byte_present) begin
      if (pos_r < POS_W'(FROM_LEN) && data_byte != from_char(pos_r[2:0]))
        from_nxt = 1'b0;
      if (pos_r < POS_W'(STATUS_LEN) && data_byte != status_char(pos_r[2:0]))
        status_nxt = 1'b0;
      if (pos_r < POS_W'(IMAP_LEN) && data_byte != imap_char(pos_r[2:0]))
        imap_nxt = 1'b0;
      if (data_byte == CHAR_R)
        rseen_nxt = 1'b1;
    end
  end

  // An end-of-file beat without a byte still closes a pending partial chunk.
  assign close = byte_present ?
                 (data_byte == CHAR_NL || pos_r == LAST_POS || end_of_file) :
                 (end_of_file && pos_r != '0);

  always_comb begin
    chunk.close     = close;
    chunk.blank     = byte_present && pos_r == '0 && data_byte == CHAR_NL;
    chunk.is_from   = from_nxt && pos_nxt >= POS_W'(FROM_LEN);
    chunk.is_status = status_nxt && pos_nxt >= POS_W'(STATUS_LEN);
    chunk.is_imap   = imap_nxt && pos_nxt >= POS_W'(IMAP_LEN);
    chunk.r_seen    = rseen_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      from_r   <= 1'b1;
      status_r <= 1'b1;
      imap_r   <= 1'b1;
      rseen_r  <= 1'b0;
    end else if (en) begin
      if (close) begin
        pos_r    <= '0;
        from_r   <= 1'b1;
        status_r <= 1'b1;
        imap_r   <= 1'b1;
        rseen_r  <= 1'b0;
      end else begin
        pos_r    <= pos_nxt;
        from_r   <= from_nxt;
        status_r <= status_nxt;
        imap_r   <= imap_nxt;
        rseen_r  <= rseen_nxt;
      end
    end
  end

endmodule

`default_nettype wire

### sv/mmc_count.sv
// ---------------------------------------------------------------------------
// mmc_count
// Header tracking and message/read counters; forms the end-of-file result.
// ---------------------------------------------------------------------------
`default_nettype none

module mmc_count
  import mmc_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          end_of_file,
  input  wire chunk_close_t  chunk,
  output logic [15:0]        total_messages,
  output logic signed [16:0] unread_messages
);

  logic        in_header_r, in_header_nxt;
  logic        opens_r, opens_nxt;
  logic        pseudo_r, pseudo_nxt;
  logic [15:0] from_cnt_r, from_cnt_nxt;
  logic [15:0] read_cnt_r, read_cnt_nxt;
  logic [15:0] rd_adj;

  always_comb begin
    in_header_nxt = in_header_r;
    opens_nxt     = opens_r;
    pseudo_nxt    = pseudo_r;
    from_cnt_nxt  = from_cnt_r;
    read_cnt_nxt  = read_cnt_r;
    if (chunk.close) begin
      if (in_header_r && chunk.is_imap)
        pseudo_nxt = 1'b1;
      if (chunk.blank) begin
        if (in_header_r)
          in_header_nxt = 1'b0;
        else
          opens_nxt = 1'b1;
      end else if (chunk.is_from) begin
        if (opens_r)
          in_header_nxt = 1'b1;
        if ((opens_r || in_header_r) && from_cnt_r != 16'hFFFF)
          from_cnt_nxt = from_cnt_r + 16'd1;
      end else begin
        opens_nxt = 1'b0;
        if (in_header_r && chunk.is_status && chunk.r_seen && read_cnt_r != 16'hFFFF)
          read_cnt_nxt = read_cnt_r + 16'd1;
      end
    end
  end

  // The X-IMAP pseudo message takes one message and one read mark with it.
  always_comb begin
    total_messages = from_cnt_nxt;
    rd_adj         = read_cnt_nxt;
    if (from_cnt_nxt != '0 && pseudo_nxt) begin
      total_messages = from_cnt_nxt - 16'd1;
      if (read_cnt_nxt != '0)
        rd_adj = read_cnt_nxt - 16'd1;
    end
    unread_messages = $signed({1'b0, total_messages} - {1'b0, rd_adj});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_header_r <= 1'b0;
      opens_r     <= 1'b1;
      pseudo_r    <= 1'b0;
      from_cnt_r  <= '0;
      read_cnt_r  <= '0;
    end else if (en) begin
      if (end_of_file) begin
        in_header_r <= 1'b0;
        opens_r     <= 1'b1;
        pseudo_r    <= 1'b0;
        from_cnt_r  <= '0;
        read_cnt_r  <= '0;
      end else begin
        in_header_r <= in_header_nxt;
        opens_r     <= opens_nxt;
        pseudo_r    <= pseudo_nxt;
        from_cnt_r  <= from_cnt_nxt;
        read_cnt_r  <= read_cnt_nxt;
      end
    end
  end

endmodule

`default_nettype wire

### sv/mbox_message_counter_unit.sv
// An accepted end-of-file beat lands in the input register; the result register
// loads its counts when that beat advances out of the input register.
// Throughput: one beat per cycle; only an end-of-file beat waits, and only while
// the result register still holds an untaken result.
// Reset (rst_n low, synchronous) clears all chunk and header state and counts;
// every end-of-file beat returns that state to the same reset values.
// ---------------------------------------------------------------------------
// mbox_message_counter_unit
// Counts total and unread messages of a mailbox streamed one byte per beat.
// ---------------------------------------------------------------------------
`default_nettype none

module mbox_message_counter_unit
  import mmc_pkg::*;
#(
  parameter int LINE_CHUNK = LINE_CHUNK_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_data_byte,
  input  wire logic          in_byte_present,
  input  wire logic          in_end_of_file,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [15:0]        out_total_messages,
  output logic signed [16:0] out_unread_messages
);

  logic               valid_r;
  logic [7:0]         byte_r;
  logic               present_r;
  logic               eof_r;
  logic               advance;
  chunk_close_t       chunk;
  logic [15:0]        total;
  logic signed [16:0] unread;
  logic               out_valid_r;
  logic [15:0]        total_r;
  logic signed [16:0] unread_r;

  // Only an end-of-file beat needs room in the result register.
  assign advance  = valid_r && (!eof_r || !out_valid_r || out_ready);
  assign in_ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r    <= in_data_byte;
      present_r <= in_byte_present;
      eof_r     <= in_end_of_file;
    end
  end

  mmc_chunk #(
    .LINE_CHUNK (LINE_CHUNK)
  ) u_chunk (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (advance),
    .data_byte    (byte_r),
    .byte_present (present_r),
    .end_of_file  (eof_r),
    .chunk        (chunk)
  );

  mmc_count u_count (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (advance),
    .end_of_file     (eof_r),
    .chunk           (chunk),
    .total_messages  (total),
    .unread_messages (unread)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && eof_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && eof_r) begin
      total_r  <= total;
      unread_r <= unread;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_total_messages  = total_r;
  assign out_unread_messages = unread_r;

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking testbench of the mailbox message counter. Mailbox files are
// streamed one byte per beat under random idling and back-pressure, and every
// end-of-file result is compared against a local count of messages and read
// marks kept beat by beat.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
  import mmc_pkg::*;

  localparam int          LINE_LIMIT  = LINE_CHUNK_DEF;
  localparam logic [39:0] FROM_TEXT   = "From ";
  localparam logic [63:0] STATUS_TEXT = "Status: ";
  localparam logic [63:0] IMAP_TEXT   = "X-IMAP: ";

  typedef struct packed {
    logic [15:0]        total;
    logic signed [16:0] unread;
  } counts_t;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       eof;
  } beat_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_data_byte = 8'h00;
  logic               in_byte_present = 1'b0;
  logic               in_end_of_file = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [15:0]        out_total_messages;
  logic signed [16:0] out_unread_messages;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles_req = 0;
  int error_count = 0;
  int beats_counted = 0;
  int mailboxes_done = 0;

  counts_t expected_counts[$];
  beat_t   file_beats[$];

  // Local copy of the line and header tracking state.
  int unsigned line_len;
  logic        from_hit, status_hit, imap_hit, r_in_line;
  logic        hdr_open, from_may_open, pseudo_seen;
  logic [15:0] msg_count, read_marks;

  mbox_message_counter_unit #(
    .LINE_CHUNK(LINE_LIMIT)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_data_byte       (in_data_byte),
    .in_byte_present    (in_byte_present),
    .in_end_of_file     (in_end_of_file),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_total_messages (out_total_messages),
    .out_unread_messages(out_unread_messages)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ------------------------------------------------------------------------
  // Message counting
  // ------------------------------------------------------------------------
  function automatic logic [7:0] prefix_char(input logic [63:0] text, input int n,
                                             input int k);
    return text[8*(n-1-k) +: 8];
  endfunction

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic void clear_line();
    line_len   = 0;
    from_hit   = 1'b1;
    status_hit = 1'b1;
    imap_hit   = 1'b1;
    r_in_line  = 1'b0;
  endfunction

  function automatic void clear_mailbox();
    clear_line();
    hdr_open      = 1'b0;
    from_may_open = 1'b1;
    pseudo_seen   = 1'b0;
    msg_count     = 16'd0;
    read_marks    = 16'd0;
  endfunction

  function automatic void close_line(input logic blank);
    logic is_from, is_status, is_imap;
    is_from   = from_hit && (line_len >= FROM_LEN);
    is_status = status_hit && (line_len >= STATUS_LEN);
    is_imap   = imap_hit && (line_len >= IMAP_LEN);
    if (hdr_open && is_imap) pseudo_seen = 1'b1;
    if (blank) begin
      if (hdr_open) hdr_open = 1'b0;
      else from_may_open = 1'b1;
    end else if (is_from) begin
      if (from_may_open) hdr_open = 1'b1;
      if (hdr_open) msg_count = bump(msg_count);
    end else begin
      from_may_open = 1'b0;
      if (hdr_open && is_status && r_in_line) read_marks = bump(read_marks);
    end
    clear_line();
  endfunction

  function automatic void count_beat(input beat_t bt);
    logic        blank;
    logic [15:0] total, reads;
    counts_t     c;
    if (bt.present) begin
      blank = (line_len == 0) && (bt.data == CHAR_NL);
      if (line_len < FROM_LEN && bt.data != prefix_char(FROM_TEXT, FROM_LEN, line_len))
        from_hit = 1'b0;
      if (line_len < STATUS_LEN &&
          bt.data != prefix_char(STATUS_TEXT, STATUS_LEN, line_len))
        status_hit = 1'b0;
      if (line_len < IMAP_LEN && bt.data != prefix_char(IMAP_TEXT, IMAP_LEN, line_len))
        imap_hit = 1'b0;
      if (bt.data == CHAR_R) r_in_line = 1'b1;
      line_len++;
      if (bt.data == CHAR_NL || line_len >= LINE_LIMIT - 1 || bt.eof) close_line(blank);
    end else if (bt.eof && line_len != 0) begin
      close_line(1'b0);
    end
    if (bt.eof) begin
      total = msg_count;
      reads = read_marks;
      // The X-IMAP pseudo message is not a real message.
      if (total != 0 && pseudo_seen) begin
        total--;
        if (reads != 0) reads--;
      end
      c.total  = total;
      c.unread = {1'b0, total} - {1'b0, reads};
      expected_counts.push_back(c);
      clear_mailbox();
    end
  endfunction

  // ------------------------------------------------------------------------
  // Sender, receiver and result check
  // ------------------------------------------------------------------------
  task automatic send_beat(input logic [7:0] b, input logic present, input logic eof);
    beat_t bt;
    bt.data    = b;
    bt.present = present;
    bt.eof     = eof;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= b;
    in_byte_present <= present;
    in_end_of_file  <= eof;
    do @(posedge clk); while (!in_ready);
    if (present || eof) beats_counted++;
    if (eof) mailboxes_done++;
    count_beat(bt);
  endtask

  task automatic send_text(input string s, input logic eof_last);
    for (int i = 0; i < s.len(); i++)
      send_beat(s[i], 1'b1, eof_last && (i == s.len() - 1));
  endtask

  // The sender stops offering beats while it waits.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
  endtask

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles_req != 0) begin
        hold_left = hold_cycles_req;
        hold_cycles_req = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    counts_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_counts.size() == 0) begin
        $error("unexpected result: total_messages %0d, unread_messages %0d",
               out_total_messages, out_unread_messages);
        error_count++;
      end else begin
        want = expected_counts.pop_front();
        if (out_total_messages !== want.total) begin
          $error("total_messages: expected %0d, actual %0d", want.total, out_total_messages);
          error_count++;
        end
        if (out_unread_messages !== want.unread) begin
          $error("unread_messages: expected %0d, actual %0d", want.unread,
                 out_unread_messages);
          error_count++;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Random mailbox files
  // ------------------------------------------------------------------------
  function automatic void add_beat(input logic [7:0] b, input logic present,
                                   input logic eof);
    beat_t bt;
    bt.data    = b;
    bt.present = present;
    bt.eof     = eof;
    file_beats.push_back(bt);
  endfunction

  // A real byte, now and then followed by an idle beat.
  function automatic void put(input logic [7:0] b);
    add_beat(b, 1'b1, 1'b0);
    if ($urandom_range(99) < 4) add_beat(8'($urandom), 1'b0, 1'b0);
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function automatic void put_word();
    int n;
    n = $urandom_range(0, 6);
    repeat (n) put(8'($urandom_range(33, 126)));
  endfunction

  // A line that resembles one of the prefixes but may be cut short or bent.
  function automatic void put_near_miss();
    logic [63:0] text;
    logic [7:0]  c;
    int          n, cut, bend;
    case ($urandom_range(0, 2))
      0:       begin text = FROM_TEXT;   n = FROM_LEN;   end
      1:       begin text = STATUS_TEXT; n = STATUS_LEN; end
      default: begin text = IMAP_TEXT;   n = IMAP_LEN;   end
    endcase
    cut  = $urandom_range(1, n);
    bend = $urandom_range(0, n);
    for (int k = 0; k < cut; k++) begin
      c = prefix_char(text, n, k);
      if (k == bend) c = c ^ 8'($urandom_range(1, 255));
      put(c);
    end
    if ($urandom_range(1)) put(CHAR_R);
    put_word();
    put(CHAR_NL);
  endfunction

  function automatic void put_header_line();
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        put_text("Status: ");
        n = $urandom_range(0, 3);
        repeat (n) put($urandom_range(1) ? CHAR_R : 8'h4F);
        put(CHAR_NL);
      end
      4: begin
        put_text("X-IMAP: ");
        put_word();
        put(CHAR_NL);
      end
      5, 6: put_near_miss();
      default: begin
        put_text("Subject: ");
        put_word();
        put(CHAR_NL);
      end
    endcase
  endfunction

  function automatic void put_body_line();
    int n;
    case ($urandom_range(0, 5))
      0: put(CHAR_NL);
      1: begin
        put_text("From ");
        put_word();
        put(CHAR_NL);
      end
      5: begin
        put(CHAR_R);
        put_word();
        put(CHAR_NL);
      end
      default: begin
        n = $urandom_range(0, 10);
        repeat (n) put(8'($urandom_range(0, 255)));
        put(CHAR_NL);
      end
    endcase
  endfunction

  function automatic void build_mailbox();
    int msgs, lines;
    file_beats.delete();
    if ($urandom_range(99) < 20) begin
      // Noise: lines in no particular order.
      lines = $urandom_range(1, 6);
      repeat (lines) begin
        if ($urandom_range(1)) put_header_line();
        else put_body_line();
      end
    end else begin
      msgs = $urandom_range(1, 3);
      repeat (msgs) begin
        put_text("From ");
        put_word();
        put(CHAR_NL);
        lines = $urandom_range(0, 4);
        repeat (lines) put_header_line();
        if ($urandom_range(99) < 90) put(CHAR_NL);
        lines = $urandom_range(0, 3);
        repeat (lines) put_body_line();
        if ($urandom_range(99) < 70) put(CHAR_NL);
      end
    end
    case ($urandom_range(0, 3))
      0: begin
        if (file_beats.size() == 0) add_beat(8'($urandom), 1'b0, 1'b1);
        else file_beats[file_beats.size() - 1].eof = 1'b1;
      end
      1: add_beat(8'($urandom), 1'b0, 1'b1);
      2: begin
        // Last line without a newline, closed by the empty end marker.
        if ($urandom_range(1)) put_text("Status: R");
        else put_word();
        add_beat(8'($urandom), 1'b0, 1'b1);
      end
      default: add_beat(8'($urandom), 1'b1, 1'b1);
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  task automatic test_directed_edges();
    // Empty file: the end marker alone.
    send_beat(8'hFF, 1'b0, 1'b1);
    // Idle beat, then a lone zero byte that ends the file.
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'h00, 1'b1, 1'b1);
    // Line shorter than the prefix, left open and closed by the end marker.
    send_text("Fro", 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    // Blank line, then an all-ones byte that ends the file.
    send_beat(CHAR_NL, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b1);
    // A zero byte inside a Status line does not hide the R after it.
    send_text("From \n", 1'b0);
    send_text("Status: ", 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(CHAR_R, 1'b1, 1'b1);
  endtask

  task automatic test_more_reads_than_messages();
    // The pseudo message drops one message and one read mark.
    send_text("From \nX-IMAP: \nStatus: R\nStatus: R\n", 1'b0);
    send_beat(8'h5A, 1'b0, 1'b1);
  endtask

  task automatic test_random_mailboxes(input int beat_goal, input int file_goal);
    int first_beat, first_file;
    first_beat = beats_counted;
    first_file = mailboxes_done;
    while (beats_counted - first_beat < beat_goal ||
           mailboxes_done - first_file < file_goal) begin
      build_mailbox();
      foreach (file_beats[i])
        send_beat(file_beats[i].data, file_beats[i].present, file_beats[i].eof);
    end
  endtask

  task automatic test_backpressure();
    // Results pile up behind a long receiver stall and the input must stall.
    hold_cycles_req = 500;
    repeat (12) send_text("From x\n", 1'b1);
    wait_for_results();
  endtask

  task automatic test_line_split();
    send_text("From \n", 1'b0);
    // A long line cut by the limit alone; the Status line after it still counts.
    repeat (LINE_LIMIT - 1) send_beat(CHAR_R, 1'b1, 1'b0);
    send_text("Status: R\n", 1'b1);
    wait_for_results();
  endtask

  initial begin
    clear_mailbox();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 14;
    recv_idle_pct = 76;
    test_directed_edges();
    test_more_reads_than_messages();
    test_random_mailboxes(240, 3);

    send_idle_pct = 76;
    recv_idle_pct = 14;
    test_backpressure();
    test_random_mailboxes(230, 3);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_line_split();
    test_random_mailboxes(240, 3);

    in_valid <= 1'b0;
    wait_for_results();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("mbox_message_counter_unit regression: pass");
    end else begin
      $display("mbox_message_counter_unit regression: fail");
    end
    $finish;
  end

  // The slowest correct run is well under 0.2 ms of simulated time.
  initial begin
    #10_000_000;
    $display("mbox_message_counter_unit regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
